@@ hdl/utf8v_pkg.sv @@
// utf8v_pkg: types and constants shared by the UTF-8 stream validator.
// Used by utf8v_step, utf8v_rsp_reg and utf8_stream_validator.
// No dependencies.
package utf8v_pkg;

   localparam int unsigned CP_W = 21;

   // lead byte classes: (byte & mask) == code
   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_CODE  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK  = 8'hF0;
   localparam logic [7:0] LEAD3_CODE  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK  = 8'hF8;
   localparam logic [7:0] LEAD4_CODE  = 8'hF0;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_CODE   = 8'h80;

   // sequence lengths, counted in continuation bytes
   localparam logic [1:0] SEQ_NONE = 2'd0;
   localparam logic [1:0] SEQ_TWO  = 2'd1;
   localparam logic [1:0] SEQ_THREE = 2'd2;
   localparam logic [1:0] SEQ_FOUR = 2'd3;

   // shortest legal code point per sequence length
   localparam logic [CP_W-1:0] FLOOR_TWO   = 21'h00080;
   localparam logic [CP_W-1:0] FLOOR_THREE = 21'h00800;
   localparam logic [CP_W-1:0] FLOOR_FOUR  = 21'h10000;
   localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LO     = 21'h0D800;
   localparam logic [CP_W-1:0] SURR_HI     = 21'h0DFFF;

   typedef struct packed {
      logic [1:0]      pending;
      logic [1:0]      seq_len;
      logic [CP_W-1:0] cp;
      logic            error;
   } state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       empty_span;
   } req_type;

   typedef struct packed {
      logic error_seen;
      logic span_end;
      logic span_valid;
   } rsp_type;

endpackage

@@ hdl/utf8v_step.sv @@
// utf8v_step: combinational decode of one byte against the running state.
// Produces the next decoder state and the result beat. Depends on utf8v_pkg.
module utf8v_step
   import utf8v_pkg::*;
(
   input  state_type st,
   input  req_type   req,
   output state_type st_next,
   output rsp_type   rsp
);

   logic [7:0]      b;
   logic [CP_W-1:0] cp_acc;
   logic [CP_W-1:0] floor_value;
   logic [1:0]      pend_dec;
   logic            closing;
   logic            verdict_ok;
   state_type       nx;

   assign b = req.data_byte;
   assign cp_acc = {st.cp[CP_W-7:0], b[5:0]};
   assign pend_dec = st.pending - 2'd1;

   always_comb begin
      case (st.seq_len)
         SEQ_TWO:   floor_value = FLOOR_TWO;
         SEQ_THREE: floor_value = FLOOR_THREE;
         default:   floor_value = FLOOR_FOUR;
      endcase
   end

   always_comb begin
      nx = st;
      if (!st.error) begin
         if (st.pending == 2'd0) begin
            if (b == 8'h00) begin
               nx.error = 1'b1;
            end else if (b < ASCII_LIMIT) begin
               nx = st;
            end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
               nx.cp      = {16'd0, b[4:0]};
               nx.seq_len = SEQ_TWO;
               nx.pending = SEQ_TWO;
            end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
               nx.cp      = {17'd0, b[3:0]};
               nx.seq_len = SEQ_THREE;
               nx.pending = SEQ_THREE;
            end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
               nx.cp      = {18'd0, b[2:0]};
               nx.seq_len = SEQ_FOUR;
               nx.pending = SEQ_FOUR;
            end else begin
               nx.error = 1'b1;
            end
         end else if ((b & CONT_MASK) != CONT_CODE) begin
            nx.error = 1'b1;
         end else begin
            nx.cp      = cp_acc;
            nx.pending = pend_dec;
            if (pend_dec == 2'd0) begin
               // sequence complete: overlong, out of range, surrogate
               if (cp_acc < floor_value || cp_acc > CP_MAX ||
                   (cp_acc >= SURR_LO && cp_acc <= SURR_HI)) begin
                  nx.error = 1'b1;
               end
               nx.cp      = '0;
               nx.seq_len = SEQ_NONE;
            end
         end
      end
   end

   // an empty-span beat closes on the state as it stands, without the byte
   assign closing = req.empty_span || req.last_byte;
   assign verdict_ok = req.empty_span ? (!st.error && st.pending == 2'd0)
                                      : (!nx.error && nx.pending == 2'd0);

   assign rsp.error_seen = closing ? !verdict_ok : nx.error;
   assign rsp.span_end   = closing;
   assign rsp.span_valid = closing && verdict_ok;

   assign st_next = closing ? '0 : nx;

endmodule

@@ hdl/utf8v_rsp_reg.sv @@
// utf8v_rsp_reg: result register on the master side of the validator.
// Holds one result beat until taken. Depends on utf8v_pkg.
module utf8v_rsp_reg
   import utf8v_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type rsp_in,
   input  logic    out_ready,
   output logic    out_valid,
   output rsp_type rsp_out,
   output logic    can_load
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign rsp_out   = data_ff;

endmodule

@@ hdl/utf8_stream_validator.sv @@
// utf8_stream_validator: UTF-8 span checker, one byte per beat, top level.
// An accepted req beat reaches its rsp beat through the input register, decode
// and the result register. Throughput: one beat per cycle while rsp_tready is
// high, set by the decoder state update: a single short decode between registers.
// Reset (synchronous, active high) empties both registers and clears decode state.
// Depends on utf8v_pkg, utf8v_step, utf8v_rsp_reg.
module utf8_stream_validator
   import utf8v_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   input  logic       req_tuser,   // [0] empty_span
   // result stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] error_seen, [1] span_valid, [7:2] zero
   output logic       rsp_tlast    // span_end
);

   // input register
   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_req_ff;
   logic      in_take;
   logic      advance;

   // decoder state
   state_type st_ff;
   state_type st_in;
   state_type st_step;

   rsp_type   step_rsp;
   rsp_type   out_rsp;
   logic      out_can_load;

   // The held byte moves into decode once the result register has room; the
   // input register refills in the same cycle, so the stream never bubbles.
   assign advance     = in_valid_ff && out_can_load;
   assign req_tready  = !in_valid_ff || advance;
   assign in_take     = req_tvalid && req_tready;
   assign in_valid_in = in_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_req_ff <= '{data_byte: req_tdata, last_byte: req_tlast,
                        empty_span: req_tuser};
      end
   end

   utf8v_step u_step (
      .st      (st_ff),
      .req     (in_req_ff),
      .st_next (st_step),
      .rsp     (step_rsp)
   );

   // state only moves when its beat is committed to the result register
   assign st_in = advance ? st_step : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   utf8v_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .rsp_in    (step_rsp),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .rsp_out   (out_rsp),
      .can_load  (out_can_load)
   );

   assign rsp_tdata = {6'd0, out_rsp.span_valid, out_rsp.error_seen};
   assign rsp_tlast = out_rsp.span_end;

`ifndef SYNTHESIS
   // a span that closes leaves the decoder clean for the next one
   a_clear_on_close: assert property (@(posedge clock) disable iff (reset)
      advance && step_rsp.span_end |=> st_ff == '0)
      else $error("decoder state not cleared after span end");

   // verdict and error flag agree at span end; no verdict mid-span
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_rsp.span_end ? (out_rsp.span_valid != out_rsp.error_seen)
                                       : !out_rsp.span_valid))
      else $error("span verdict inconsistent");

   // pending count never exceeds the length of the open sequence
   a_pending: assert property (@(posedge clock) disable iff (reset)
      st_ff.pending != 2'd0 |-> st_ff.seq_len >= st_ff.pending)
      else $error("pending continuations exceed sequence length");

   // error is sticky until the span closes
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      st_ff.error && !(advance && step_rsp.span_end) |=> st_ff.error)
      else $error("error flag dropped inside a span");

   // a decoded beat reports any error already held in the state
   a_err_report: assert property (@(posedge clock) disable iff (reset)
      advance && st_ff.error |-> step_rsp.error_seen)
      else $error("held error not reported");
`endif

endmodule
